// File: hw/rtl/maximum_frequency_stack_unit_assert.svh
// Assertion macros for the frequency stack unit and its checker.
`ifndef MAXIMUM_FREQUENCY_STACK_UNIT_ASSERT_SVH
`define MAXIMUM_FREQUENCY_STACK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frequency stack assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define MFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frequency stack assertion failed");

`endif

// File: hw/rtl/mfs_pkg.sv
package mfs_pkg;

  localparam int unsigned DATA_BITS = 32;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STAT_PUSH_DONE = 2'd0,
    STAT_POP_DONE  = 2'd1,
    STAT_POP_EMPTY = 2'd2,
    STAT_PUSH_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT
  } fsm_state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SCAN,
    CELL_POP,
    CELL_PUSH
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  typedef struct packed {
    command_t                     command;
    logic signed [DATA_BITS-1:0]  value;
  } request_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0]  popped_value;
    status_t                      status;
  } result_t;

endpackage

// File: hw/rtl/mfs_cell.sv
module mfs_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned LEVEL_BITS = 7
) (
  input  logic                    clk,
  input  mfs_pkg::cell_ctrl_t     ctrl,
  input  logic                    valid,
  input  logic [VALUE_BITS-1:0]   key,
  input  logic [LEVEL_BITS-1:0]   ins_level,
  input  logic                    prev_gt,
  input  logic [VALUE_BITS-1:0]   prev_data,
  input  logic [LEVEL_BITS-1:0]   prev_level,
  input  logic [VALUE_BITS-1:0]   next_data,
  input  logic [LEVEL_BITS-1:0]   next_level,
  input  logic [LEVEL_BITS-1:0]   next_wave,
  output logic [VALUE_BITS-1:0]   data,
  output logic [LEVEL_BITS-1:0]   level,
  output logic [LEVEL_BITS-1:0]   wave,
  output logic                    gt
);

  logic [LEVEL_BITS-1:0] cand;

  // matching copies of one value hold levels 1..k, so the largest matching level is the count
  assign cand = (valid && (data == key)) ? level : '0;
  assign gt   = valid && (level > ins_level);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      mfs_pkg::CELL_HOLD: begin
      end
      mfs_pkg::CELL_CLEAR: begin
        wave <= '0;
      end
      mfs_pkg::CELL_SCAN: begin
        wave <= (next_wave > cand) ? next_wave : cand;
      end
      mfs_pkg::CELL_POP: begin
        data  <= next_data;
        level <= next_level;
      end
      mfs_pkg::CELL_PUSH: begin
        // chain is ordered by level, then newest first
        if (!gt) begin
          if (prev_gt) begin
            data  <= key;
            level <= ins_level;
          end else begin
            data  <= prev_data;
            level <= prev_level;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/maximum_frequency_stack_unit.sv
// Frequency stack of up to DEPTH values held in a row of cells, ordered by level and then
// newest first, so the entry to pop always sits in cell 0. A pop, a pop on empty and a
// dropped push on full raise done in the cycle after the transaction is taken and keep busy
// low, so these can follow each other every cycle. A push raises busy while a maximum wave
// runs through the cells to find how many copies of the value are stored, one cell per
// cycle over the occupied cells, then inserts, and done rises as busy falls. Results are
// flagged by done for one cycle only; result keeps its value until the next answer, and
// the receiver must take them when done is high.
module maximum_frequency_stack_unit #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mfs_pkg::request_t  request,
  output logic               done,
  output mfs_pkg::result_t   result
);

  localparam int unsigned LW = $clog2(DEPTH + 1);

  mfs_pkg::fsm_state_t   state, state_next;
  logic [LW-1:0]         count, count_next;
  logic [LW-1:0]         scan_cnt, scan_cnt_next;
  logic [VALUE_BITS-1:0] key, key_next;
  logic                  done_next;
  mfs_pkg::result_t      result_next;
  mfs_pkg::cell_ctrl_t   ctrl;

  logic [VALUE_BITS-1:0] c_data  [DEPTH];
  logic [LW-1:0]         c_level [DEPTH];
  logic [LW-1:0]         c_wave  [DEPTH];
  logic                  c_gt    [DEPTH];

  logic [LW-1:0]         ins_level;
  logic [63:0]           req_wide;
  logic [VALUE_BITS-1:0] req_key;
  logic [63:0]           pop_wide;

  assign ins_level = c_wave[0] + LW'(1);
  assign req_wide  = {{(64 - mfs_pkg::DATA_BITS){request.value[mfs_pkg::DATA_BITS-1]}},
                      request.value};
  assign req_key   = req_wide[VALUE_BITS-1:0];
  assign pop_wide  = 64'(c_data[0]);
  assign busy      = (state != mfs_pkg::S_IDLE);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  cell_valid;
    logic                  prev_gt;
    logic [VALUE_BITS-1:0] prev_data, next_data;
    logic [LW-1:0]         prev_level, next_level, next_wave;

    assign cell_valid = (count > LW'(i));

    if (i == 0) begin : g_first
      assign prev_gt    = 1'b1;
      assign prev_data  = '0;
      assign prev_level = '0;
    end else begin : g_mid
      assign prev_gt    = c_gt[i-1];
      assign prev_data  = c_data[i-1];
      assign prev_level = c_level[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data  = '0;
      assign next_level = '0;
      assign next_wave  = '0;
    end else begin : g_inner
      assign next_data  = c_data[i+1];
      assign next_level = c_level[i+1];
      assign next_wave  = c_wave[i+1];
    end

    mfs_cell #(
      .VALUE_BITS (VALUE_BITS),
      .LEVEL_BITS (LW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (cell_valid),
      .key        (key),
      .ins_level  (ins_level),
      .prev_gt    (prev_gt),
      .prev_data  (prev_data),
      .prev_level (prev_level),
      .next_data  (next_data),
      .next_level (next_level),
      .next_wave  (next_wave),
      .data       (c_data[i]),
      .level      (c_level[i]),
      .wave       (c_wave[i]),
      .gt         (c_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mfs_pkg::S_IDLE;
      count    <= '0;
      scan_cnt <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    result <= result_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_cnt_next = scan_cnt;
    key_next      = key;
    done_next     = 1'b0;
    result_next   = result;
    ctrl.op       = mfs_pkg::CELL_HOLD;
    unique case (state)
      mfs_pkg::S_IDLE: begin
        if (start) begin
          if (request.command == mfs_pkg::CMD_POP) begin
            done_next = 1'b1;
            if (count == '0) begin
              result_next.popped_value = '0;
              result_next.status       = mfs_pkg::STAT_POP_EMPTY;
            end else begin
              ctrl.op                  = mfs_pkg::CELL_POP;
              count_next               = count - LW'(1);
              result_next.popped_value = pop_wide[mfs_pkg::DATA_BITS-1:0];
              result_next.status       = mfs_pkg::STAT_POP_DONE;
            end
          end else if (count == LW'(DEPTH)) begin
            done_next                = 1'b1;
            result_next.popped_value = '0;
            result_next.status       = mfs_pkg::STAT_PUSH_FULL;
          end else begin
            key_next      = req_key;
            ctrl.op       = mfs_pkg::CELL_CLEAR;
            scan_cnt_next = count;
            state_next    = (count == '0) ? mfs_pkg::S_INSERT : mfs_pkg::S_SCAN;
          end
        end
      end
      mfs_pkg::S_SCAN: begin
        // after as many steps as occupied cells the wave in cell 0 covers them all
        ctrl.op       = mfs_pkg::CELL_SCAN;
        scan_cnt_next = scan_cnt - LW'(1);
        if (scan_cnt == LW'(1)) begin
          state_next = mfs_pkg::S_INSERT;
        end
      end
      mfs_pkg::S_INSERT: begin
        ctrl.op                  = mfs_pkg::CELL_PUSH;
        count_next               = count + LW'(1);
        done_next                = 1'b1;
        result_next.popped_value = '0;
        result_next.status       = mfs_pkg::STAT_PUSH_DONE;
        state_next               = mfs_pkg::S_IDLE;
      end
      default: begin
        state_next = mfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/mfs_checker.sv
`include "maximum_frequency_stack_unit_assert.svh"

module mfs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input mfs_pkg::request_t request,
  input logic              done,
  input mfs_pkg::result_t  result
);

  logic taken;

  assign taken = start && !busy && (request.command == mfs_pkg::CMD_POP ||
                                    request.command == mfs_pkg::CMD_PUSH);

  // every transaction either answers at once or holds the unit busy
  `MFS_ASSERT_NEXT(a_taken_answers, taken, done || busy)

  // a push answers exactly when the unit frees up
  `MFS_ASSERT_NOW(a_free_with_result, !$past(rst) && $fell(busy), done)

  `MFS_ASSERT_NOW(a_quiet_while_busy, busy, !done)

  `MFS_ASSERT_NOW(a_value_only_on_pop,
                  done && result.status != mfs_pkg::STAT_POP_DONE,
                  result.popped_value == '0)

endmodule

bind maximum_frequency_stack_unit mfs_checker u_mfs_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

// File: dv/maximum_frequency_stack_unit_checker.sv
module maximum_frequency_stack_unit_checker
  import mfs_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  request_t request,
  input  logic     done,
  input  result_t  result,
  output int       mismatch_count,
  output int       outstanding
);

  logic [DATA_BITS-1:0] stored_value [DEPTH];
  int unsigned          stored_level [DEPTH];
  int unsigned          stored_count;
  result_t              expected_results [$];

  task automatic report_mismatch(input string what, input result_t got, input result_t want);
    $display("mismatch at %0t: %s, got value %0d status %0d, expected value %0d status %0d",
             $realtime, what, got.popped_value, got.status, want.popped_value, want.status);
    mismatch_count++;
  endtask

  // Newest entry at the highest level wins; arrival order kept after removal.
  function automatic result_t apply_stack_op(input request_t req);
    result_t     res;
    int unsigned copies;
    int unsigned best;
    int unsigned best_level;
    res.popped_value = '0;
    if (req.command == CMD_PUSH) begin
      if (stored_count >= DEPTH) begin
        res.status = STAT_PUSH_FULL;
      end else begin
        copies = 0;
        for (int unsigned i = 0; i < stored_count; i++)
          if (stored_value[i] == req.value) copies++;
        stored_value[stored_count] = req.value;
        stored_level[stored_count] = copies + 1;
        stored_count++;
        res.status = STAT_PUSH_DONE;
      end
    end else if (stored_count == 0) begin
      res.status = STAT_POP_EMPTY;
    end else begin
      best       = 0;
      best_level = stored_level[0];
      for (int unsigned i = 1; i < stored_count; i++) begin
        if (stored_level[i] >= best_level) begin
          best_level = stored_level[i];
          best       = i;
        end
      end
      res.popped_value = stored_value[best];
      for (int unsigned i = best; i + 1 < stored_count; i++) begin
        stored_value[i] = stored_value[i + 1];
        stored_level[i] = stored_level[i + 1];
      end
      stored_count--;
      res.status = STAT_POP_DONE;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      mismatch_count = 0;
      outstanding    = 0;
      stored_count   = 0;
      expected_results.delete();
    end else begin
      // compare before predicting: a new transaction cannot finish in its own cycle
      if (done) begin
        if (expected_results.size() == 0) begin
          want = '0;
          report_mismatch("result with no transaction outstanding", result, want);
        end else begin
          want = expected_results.pop_front();
          outstanding--;
          if (result.popped_value !== want.popped_value)
            report_mismatch("popped_value differs", result, want);
          if (result.status !== want.status)
            report_mismatch("status differs", result, want);
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_stack_op(request));
        outstanding++;
      end
    end
  end

endmodule

// File: dv/maximum_frequency_stack_unit_tb.sv
module maximum_frequency_stack_unit_tb;
  import mfs_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int          ITEM_TARGET = 1250;
  localparam int          STALL_LIMIT = 2000;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;
  int       mismatch_count;
  int       outstanding;
  int       stall_cycles;
  bit       no_idle;
  int       sent;

  maximum_frequency_stack_unit #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (DATA_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  maximum_frequency_stack_unit_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .done           (done),
    .result         (result),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("maximum_frequency_stack_unit regression: fail");
        $finish;
      end
    end
  end

  // start stays high across back-to-back transactions; only lowered ahead of a gap
  task automatic issue_op(input command_t cmd, input logic [DATA_BITS-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    request.command <= cmd;
    request.value   <= val;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  function automatic logic [DATA_BITS-1:0] pick_value(input int mode);
    logic [DATA_BITS-1:0] pool [8];
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h5, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1};
    case (mode)
      0:       return $urandom_range(0, 3);
      1:       return pool[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase_len;
    int push_pct;
    int value_mode;
    int pct_choice [5];
    pct_choice   = '{90, 70, 50, 30, 10};
    sent         = 0;
    no_idle      = 1'b0;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, value extremes, repeated values, ties, drain past empty
    issue_op(CMD_POP, $urandom);
    issue_op(CMD_PUSH, 32'h0);
    issue_op(CMD_PUSH, 32'hFFFF_FFFF);
    issue_op(CMD_PUSH, 32'h7FFF_FFFF);
    issue_op(CMD_PUSH, 32'h8000_0000);
    issue_op(CMD_PUSH, 32'hFFFF_FFFF);
    issue_op(CMD_PUSH, 32'hFFFF_FFFF);
    issue_op(CMD_PUSH, 32'h0);
    repeat (8) issue_op(CMD_POP, $urandom);
    issue_op(CMD_POP, 32'hFFFF_FFFF);

    // random phases: push-heavy ones can reach full, pop-heavy ones can reach empty
    while (sent < ITEM_TARGET) begin
      phase_len  = $urandom_range(20, 120);
      push_pct   = pct_choice[$urandom_range(0, 4)];
      value_mode = $urandom_range(0, 2);
      no_idle    = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && sent < ITEM_TARGET; k++) begin
        if ($urandom_range(1, 100) <= push_pct)
          issue_op(CMD_PUSH, pick_value(value_mode));
        else
          issue_op(CMD_POP, $urandom);
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("maximum_frequency_stack_unit regression: pass");
    end else begin
      $display("maximum_frequency_stack_unit regression: fail");
    end
    $finish;
  end

endmodule
